// File: sv/gcrrw_pkg.sv
// gcrrw_pkg: types, register indexes, reset values and the flux noise
// generator step shared by the GCR read/write bit engine.
// No dependencies.
package gcrrw_pkg;

  localparam int TRACK_W = 13;
  localparam int DIV_W   = 17;
  localparam int ACC_W   = 18;
  localparam int SEED_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_BYTES       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_DIVIDER      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NATIVE_READY_HOLD = 2'd2;

  localparam logic [TRACK_W-1:0] TRACK_BYTES_RST  = 13'd6250;
  localparam logic [DIV_W-1:0]   CELL_DIVIDER_RST = 17'd25000;

  localparam logic [SEED_W-1:0] NOISE_THRESHOLD = 32'h4000_0000;
  localparam logic [5:0]        NOISE_PATTERN   = 6'h08;
  localparam logic [3:0]        ZERO_RUN_MAX    = 4'd9;
  localparam logic [2:0]        LAST_BIT        = 3'd7;

  typedef struct packed {
    logic       motor_on;
    logic       read_mode;
    logic       ready_enable;
    logic       clear_ready;
    logic       load_write_data;
    logic [7:0] write_data;
    logic       disk_bit;
  } tick_t;

  typedef struct packed {
    logic       cell_advance;
    logic       write_enable;
    logic       write_bit;
    logic [7:0] read_byte;
    logic       byte_avail;
    logic       ready_pulse;
    logic       sync_n;
  } result_t;

  typedef struct packed {
    logic             cell_hit;
    logic [ACC_W-1:0] accum;
  } rate_info_t;

  // rotate-xor step: keep seed >> 15, mix accumulator, rotate by 17
  function automatic logic [SEED_W-1:0] noise_step(input logic [SEED_W-1:0] seed,
                                                   input logic [ACC_W-1:0] accum);
    logic [SEED_W-1:0] mixed;
    mixed = seed ^ {{(SEED_W-ACC_W){1'b0}}, accum};
    return {mixed[14:0], seed[31:15]};
  endfunction

endpackage

// File: sv/gcrrw_chan_if.sv
// gcrrw_chan_if: valid/ready channel carrying one payload per transaction.
// Payload type comes from gcrrw_pkg at instantiation.
interface gcrrw_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/gcr_read_write_bit_engine_top.sv
// gcr_read_write_bit_engine_top: GCR bit cell engine, one drive tick per
// transaction. Uses gcrrw_pkg, gcrrw_chan_if, gcrrw_rate, gcrrw_bits.
//
//  channel  dir  payload             transaction
//  tick     in   gcrrw_pkg::tick_t   one drive clock tick
//  result   out  gcrrw_pkg::result_t cell, write bit, byte and ready flags
//  cfg      in   index/data, we      register write, no read-back
//
// A tick is registered on accept and processed from the input register; its result
// register loads when the pipeline steps, so a stalled result delays it.
// One tick per cycle sustained while the result is taken.
// The whole tick (accumulator, shifters, noise) is settled by one pass of
// logic between the input and result registers.
// rst is synchronous and clears all engine state; config returns to defaults.
// A stalled result holds the pipeline; one tick may wait in the input register.
module gcr_read_write_bit_engine_top (
  input  logic                             clk,
  input  logic                             rst,
  gcrrw_chan_if.sink                       tick,
  gcrrw_chan_if.source                     result,
  input  logic                             cfg_we,
  input  logic [gcrrw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcrrw_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                          track_set;
  logic [gcrrw_pkg::TRACK_W-1:0] track_bytes;
  logic [gcrrw_pkg::DIV_W-1:0]   cell_divider;
  logic                          native_ready_hold;

  logic                  s1_valid;
  gcrrw_pkg::tick_t      s1_item;
  logic                  out_valid;
  gcrrw_pkg::result_t    out_data;
  logic                  step;
  gcrrw_pkg::rate_info_t rate;
  gcrrw_pkg::result_t    res;

  assign track_set = cfg_we && cfg_index == gcrrw_pkg::CFG_TRACK_BYTES;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_bytes       <= gcrrw_pkg::TRACK_BYTES_RST;
      cell_divider      <= gcrrw_pkg::CELL_DIVIDER_RST;
      native_ready_hold <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcrrw_pkg::CFG_TRACK_BYTES:       track_bytes <= cfg_data[gcrrw_pkg::TRACK_W-1:0];
        gcrrw_pkg::CFG_CELL_DIVIDER:      cell_divider <= cfg_data;
        gcrrw_pkg::CFG_NATIVE_READY_HOLD: native_ready_hold <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign step        = s1_valid && (!out_valid || result.ready);
  assign tick.ready  = !s1_valid || step;
  assign result.valid   = out_valid;
  assign result.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      s1_item <= tick.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

  gcrrw_rate u_rate (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .motor_on     (s1_item.motor_on),
    .track_bytes  (track_bytes),
    .cell_divider (cell_divider),
    .info         (rate)
  );

  gcrrw_bits u_bits (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .item              (s1_item),
    .rate              (rate),
    .native_ready_hold (native_ready_hold),
    .res               (res)
  );

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !tick.ready |-> s1_valid && out_valid) else $error("input stalled with room");
  a_step_fills_out: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid) else $error("result lost after step");
  a_track_write: assert property (@(posedge clk) disable iff (rst)
    track_set |=> track_bytes == $past(cfg_data[gcrrw_pkg::TRACK_W-1:0]))
    else $error("track length write dropped");

endmodule

// File: sv/gcrrw_rate.sv
// gcrrw_rate: fractional bit cell accumulator, one cell at most per tick.
// Uses gcrrw_pkg.
module gcrrw_rate (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          motor_on,
  input  logic [gcrrw_pkg::TRACK_W-1:0] track_bytes,
  input  logic [gcrrw_pkg::DIV_W-1:0]   cell_divider,
  output gcrrw_pkg::rate_info_t         info
);

  logic [gcrrw_pkg::ACC_W-1:0] accum;
  logic [gcrrw_pkg::ACC_W-1:0] accum_next;
  logic                        cell_hit;
  logic [gcrrw_pkg::ACC_W-1:0] div_ext;

  assign div_ext = {1'b0, cell_divider};

  always_comb begin
    accum_next = accum;
    cell_hit   = 1'b0;
    if (motor_on) begin
      if (accum_next < div_ext) begin
        accum_next = accum_next + {{(gcrrw_pkg::ACC_W-gcrrw_pkg::TRACK_W){1'b0}}, track_bytes};
      end
      if (accum_next >= div_ext) begin
        accum_next = accum_next - div_ext;
        cell_hit   = 1'b1;
      end
    end
  end

  assign info.cell_hit = cell_hit;
  assign info.accum    = accum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
    end else if (step) begin
      accum <= accum_next;
    end
  end

  a_cell_needs_motor: assert property (@(posedge clk) disable iff (rst)
    info.cell_hit |-> motor_on) else $error("cell without motor");
  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    step && !motor_on |=> $stable(accum)) else $error("accumulator moved, motor off");

endmodule

// File: sv/gcrrw_bits.sv
// gcrrw_bits: read/write shifters, sync and byte framing, byte ready and
// flux noise state. Uses gcrrw_pkg; cell timing comes from gcrrw_rate.
module gcrrw_bits (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  gcrrw_pkg::tick_t      item,
  input  gcrrw_pkg::rate_info_t rate,
  input  logic                  native_ready_hold,
  output gcrrw_pkg::result_t    res
);

  logic [31:0] noise_seed, seed_next, seed_a, seed_b;
  logic [10:0] read_shift, rs_next;
  logic [7:0]  write_shift, ws_next;
  logic [7:0]  read_hold, rh_next;
  logic [7:0]  write_hold, wh_next;
  logic [2:0]  bit_count, bc_next;
  logic        count_past_six, cps_next;
  logic [3:0]  zero_run, zr_next;
  logic        ready_flag, rf_next;
  logic        ready_edge, re_next;
  logic        enable_seen, es_next;
  logic        wen, wbit, rdy, pulse;

  assign seed_a = gcrrw_pkg::noise_step(noise_seed, rate.accum);
  assign seed_b = gcrrw_pkg::noise_step(seed_a, rate.accum);

  always_comb begin
    seed_next = noise_seed;
    rs_next   = read_shift;
    ws_next   = write_shift;
    rh_next   = read_hold;
    wh_next   = write_hold;
    bc_next   = bit_count;
    cps_next  = count_past_six;
    zr_next   = zero_run;
    rf_next   = ready_flag;
    re_next   = ready_edge;
    es_next   = enable_seen;
    wen       = 1'b0;
    wbit      = 1'b0;

    if (item.ready_enable != es_next) begin
      es_next = item.ready_enable;
      rf_next = es_next & (bc_next == gcrrw_pkg::LAST_BIT);
      re_next = re_next | rf_next;
    end
    if (item.load_write_data) begin
      wh_next = item.write_data;
    end
    if (item.clear_ready) begin
      rf_next = 1'b0;
    end

    if (rate.cell_hit && item.read_mode) begin
      rs_next = {rs_next[9:0], 1'b0};
      ws_next = {ws_next[6:0], 1'b0};
      if ((~rs_next[10:1]) != '0) begin
        bc_next = bc_next + 3'd1;
        if (bc_next == gcrrw_pkg::LAST_BIT) cps_next = 1'b1;
      end
      if (item.disk_bit) begin
        zr_next    = '0;
        rs_next[0] = 1'b1;
      end
      if (zr_next < gcrrw_pkg::ZERO_RUN_MAX) zr_next = zr_next + 4'd1;
      if (zr_next > 4'd8 && rs_next[5:0] == gcrrw_pkg::NOISE_PATTERN) begin
        seed_next = seed_a;
        if ($signed(seed_a) > $signed(gcrrw_pkg::NOISE_THRESHOLD)) begin
          rs_next[0] = 1'b1;
          if (!cps_next) begin
            seed_next = seed_b;
            if ($signed(seed_b) > 0) begin
              bc_next = bc_next + 3'd1;
              if (bc_next == gcrrw_pkg::LAST_BIT) cps_next = 1'b1;
              rs_next = {rs_next[9:0], 1'b0};
            end
          end
        end else if (rs_next[3:0] == 4'd0) begin
          rs_next[0] = 1'b1;
        end
      end else if (rs_next[3:0] == 4'd0) begin
        rs_next[0] = 1'b1;
      end
      if ((~rs_next[9:0]) != '0) begin
        if (bc_next == gcrrw_pkg::LAST_BIT) rh_next = rs_next[7:0];
        if (bc_next != gcrrw_pkg::LAST_BIT) begin
          rf_next = rf_next & native_ready_hold;
        end else begin
          re_next = re_next | (es_next & ~rf_next);
          rf_next = rf_next | es_next;
          ws_next = rs_next[7:0];
        end
      end else begin
        bc_next  = '0;
        cps_next = 1'b0;
      end
    end else if (rate.cell_hit) begin
      bc_next = bc_next + 3'd1;
      if (bc_next == gcrrw_pkg::LAST_BIT) cps_next = 1'b1;
      rs_next = {rs_next[9:0], 1'b0};
      if (rs_next[3:0] == 4'd0) rs_next[0] = 1'b1;
      wen     = 1'b1;
      wbit    = ws_next[7];
      ws_next = {ws_next[6:0], 1'b0};
      if (bc_next != gcrrw_pkg::LAST_BIT) begin
        rf_next = rf_next & native_ready_hold;
      end else begin
        re_next = re_next | (es_next & ~rf_next);
        rf_next = rf_next | es_next;
        ws_next = wh_next;
      end
    end

    if (!es_next)               rdy = 1'b0;
    else if (native_ready_hold) rdy = rf_next;
    else                        rdy = (bc_next == gcrrw_pkg::LAST_BIT);

    pulse = re_next;
    re_next = 1'b0;
  end

  assign res.cell_advance = rate.cell_hit;
  assign res.write_enable = wen;
  assign res.write_bit    = wbit;
  assign res.read_byte    = rh_next;
  assign res.byte_avail   = rdy;
  assign res.ready_pulse  = pulse;
  assign res.sync_n       = !(item.read_mode && rs_next[9:0] == 10'h3ff);

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed     <= '0;
      read_shift     <= '0;
      write_shift    <= '0;
      read_hold      <= '0;
      write_hold     <= '0;
      bit_count      <= '0;
      count_past_six <= 1'b0;
      zero_run       <= '0;
      ready_flag     <= 1'b0;
      ready_edge     <= 1'b0;
      enable_seen    <= 1'b0;
    end else if (step) begin
      noise_seed     <= seed_next;
      read_shift     <= rs_next;
      write_shift    <= ws_next;
      read_hold      <= rh_next;
      write_hold     <= wh_next;
      bit_count      <= bc_next;
      count_past_six <= cps_next;
      zero_run       <= zr_next;
      ready_flag     <= rf_next;
      ready_edge     <= re_next;
      enable_seen    <= es_next;
    end
  end

  a_zero_run_sat: assert property (@(posedge clk) disable iff (rst)
    zero_run <= gcrrw_pkg::ZERO_RUN_MAX) else $error("zero run past saturation");
  a_last_bit_past_six: assert property (@(posedge clk) disable iff (rst)
    bit_count == gcrrw_pkg::LAST_BIT |-> count_past_six) else $error("past-six flag lost");
  a_no_write_in_read: assert property (@(posedge clk) disable iff (rst)
    item.read_mode |-> !res.write_enable) else $error("write strobe while reading");

endmodule
